// ===== rtl/core/wsd_pkg.sv =====
`timescale 1ns / 1ps

package wsd_pkg;

  // Reset value of the payload length limit for the 64-bit length form
  localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

  // Codes of the 7-bit length field that select an extended length
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Header byte counts at which an extended field or the mask key completes
  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] MASK_LAST  = 3'd3;

  typedef enum logic [6:0] {
    PH_HDR0  = 7'b0000001,
    PH_HDR1  = 7'b0000010,
    PH_EXT16 = 7'b0000100,
    PH_EXT64 = 7'b0001000,
    PH_MASK  = 7'b0010000,
    PH_DATA  = 7'b0100000,
    PH_HALT  = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [3:0]  opcode;
    logic        last;
  } result_t;

endpackage

// ===== rtl/core/wsd_parser.sv =====
`timescale 1ns / 1ps

module wsd_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          byte_in,
  input  logic [31:0]         max_len,
  output logic                res_valid,
  output wsd_pkg::result_t    res
);
  import wsd_pkg::*;

  phase_t       phase, phase_next;
  logic [3:0]   opcode, opcode_next;
  logic         mask_on, mask_on_next;
  logic [2:0]   hdr_cnt, hdr_cnt_next;
  logic [31:0]  mask_key, mask_key_next;
  logic [63:0]  len_left, len_left_next;
  logic [1:0]   lane, lane_next;

  logic         len_known;
  logic         begin_pay;
  logic [7:0]   key_byte;

  // Key byte for the current lane: lane 0 takes the first key byte received
  assign key_byte = mask_key[{~lane, 3'b000} +: 8];

  always_comb begin
    phase_next    = phase;
    opcode_next   = opcode;
    mask_on_next  = mask_on;
    hdr_cnt_next  = hdr_cnt;
    mask_key_next = mask_key;
    len_left_next = len_left;
    lane_next     = lane;
    len_known     = 1'b0;
    begin_pay     = 1'b0;
    res_valid     = 1'b0;
    res.kind      = KIND_DATA;
    res.data      = 8'd0;
    res.opcode    = opcode;
    res.last      = 1'b0;

    unique case (phase)
      PH_HDR0: begin
        opcode_next = byte_in[3:0];
        phase_next  = PH_HDR1;
      end
      PH_HDR1: begin
        mask_on_next  = byte_in[7];
        hdr_cnt_next  = 3'd0;
        len_left_next = 64'd0;
        if (byte_in[6:0] == LEN7_EXT16) begin
          phase_next = PH_EXT16;
        end else if (byte_in[6:0] == LEN7_EXT64) begin
          phase_next = PH_EXT64;
        end else begin
          len_left_next = {57'd0, byte_in[6:0]};
          len_known     = 1'b1;
        end
      end
      PH_EXT16: begin
        len_left_next = {48'd0, len_left[7:0], byte_in};
        if (hdr_cnt >= EXT16_LAST) begin
          len_known = 1'b1;
        end else begin
          hdr_cnt_next = hdr_cnt + 3'd1;
        end
      end
      PH_EXT64: begin
        len_left_next = {len_left[55:0], byte_in};
        if (hdr_cnt >= EXT64_LAST) begin
          hdr_cnt_next = 3'd0;
          if (len_left_next > {32'd0, max_len}) begin
            // Drop the connection: report once, then ignore everything
            phase_next = PH_HALT;
            res_valid  = 1'b1;
            res.kind   = KIND_ERROR;
            res.last   = 1'b1;
          end else begin
            len_known = 1'b1;
          end
        end else begin
          hdr_cnt_next = hdr_cnt + 3'd1;
        end
      end
      PH_MASK: begin
        mask_key_next = {mask_key[23:0], byte_in};
        if (hdr_cnt >= MASK_LAST) begin
          begin_pay = 1'b1;
        end else begin
          hdr_cnt_next = hdr_cnt + 3'd1;
        end
      end
      PH_DATA: begin
        lane_next     = lane + 2'd1;
        len_left_next = len_left - 64'd1;
        res_valid     = 1'b1;
        res.data      = byte_in ^ key_byte;
        if (len_left == 64'd1) begin
          phase_next = PH_HDR0;
          res.last   = 1'b1;
        end
      end
      PH_HALT: begin
      end
      default: begin
      end
    endcase

    if (len_known) begin
      hdr_cnt_next  = 3'd0;
      mask_key_next = 32'd0;
      if (mask_on_next) begin
        phase_next = PH_MASK;
      end else begin
        begin_pay = 1'b1;
      end
    end

    if (begin_pay) begin
      lane_next    = 2'd0;
      hdr_cnt_next = 3'd0;
      if (len_left_next == 64'd0) begin
        phase_next = PH_HDR0;
        res_valid  = 1'b1;
        res.kind   = KIND_EMPTY;
        res.last   = 1'b1;
      end else begin
        phase_next = PH_DATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HDR0;
      opcode   <= 4'd0;
      mask_on  <= 1'b0;
      hdr_cnt  <= 3'd0;
      mask_key <= 32'd0;
      len_left <= 64'd0;
      lane     <= 2'd0;
    end else if (step) begin
      phase    <= phase_next;
      opcode   <= opcode_next;
      mask_on  <= mask_on_next;
      hdr_cnt  <= hdr_cnt_next;
      mask_key <= mask_key_next;
      len_left <= len_left_next;
      lane     <= lane_next;
    end
  end

endmodule

// ===== rtl/core/wsd_out_reg.sv =====
`timescale 1ns / 1ps

module wsd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              res_valid,
  input  wsd_pkg::result_t  res,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output wsd_pkg::result_t  out_res
);
  import wsd_pkg::*;

  // Room for a new result when empty or when the held one leaves this cycle
  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

endmodule

// ===== rtl/core/websocket_frame_deframer_top.sv =====
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// -------   --------------------  -------------------------------------------
// in        in_valid / in_ready   in_byte
// out       out_valid / out_ready result_kind, data_byte, frame_opcode_out,
//                                 last_of_frame
// cfg       cfg_valid / cfg_ready cfg_data (max_payload_len)
//
// One byte per cycle sustained while the output is not stalled. A byte is held
// in the input register, is parsed there by the header/payload state logic,
// and its result (if any) is registered in the output register. Synchronous
// reset clears the parse state and sets the length limit to 1 MiB. A stalled
// output holds the input register, which in turn drops in_ready; the config
// port is always ready.

module websocket_frame_deframer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  data_byte,
  output logic [3:0]  frame_opcode_out,
  output logic        last_of_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import wsd_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic [31:0] max_len;
  logic        space;
  logic        step;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  // Parse the held item only when the output register can take its result
  assign step     = s1_valid && space;
  assign in_ready = !s1_valid || space;
  assign cfg_ready = 1'b1;

  // Input register: advance whenever the held item is consumed or empty
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
    end
  end

  // Length limit for the 64-bit length form
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len <= cfg_data;
    end
  end

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .byte_in   (s1_byte),
    .max_len   (max_len),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign result_kind      = out_res.kind;
  assign data_byte        = out_res.data;
  assign frame_opcode_out = out_res.opcode;
  assign last_of_frame    = out_res.last;

endmodule
